FILE: hdl/tsrb_pkg.sv
// Shared types and constants for the TCP sequence reorder buffer.
// No dependencies.
`timescale 1ns / 1ps

package tsrb_pkg;

  typedef enum logic [2:0] {
    KIND_IGNORE = 3'd0,
    KIND_SYN    = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_RETX   = 3'd3,
    KIND_FIN    = 3'd4,
    KIND_RST    = 3'd5,
    KIND_DATA   = 3'd6
  } kind_t;

  localparam logic FUNC_PUSH = 1'b0;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    kind_t       kind;
    logic [31:0] handle;
    logic [31:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
    logic respond;
  } ctrl_t;

  typedef struct packed {
    logic is_push;
    logic can_insert;
    logic can_pop;
  } stat_t;

  function automatic logic serial_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

FILE: hdl/tsrb_ctrl.sv
// Controller state machine of the reorder buffer.
// Depends on tsrb_pkg.
`timescale 1ns / 1ps

module tsrb_ctrl import tsrb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output ctrl_t ctrl
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;
  state_t state;

  always_comb begin
    ctrl.capture = (state == S_IDLE) && start;
    ctrl.insert  = (state == S_EXEC) && stat.is_push && stat.can_insert;
    ctrl.remove  = (state == S_EXEC) && !stat.is_push && stat.can_pop;
    ctrl.respond = (state == S_EXEC);
    busy         = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_EXEC;
        S_EXEC: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/tsrb_datapath.sv
// Datapath: sorted shift-chain store, classifier and result register.
// Depends on tsrb_pkg.
`timescale 1ns / 1ps

module tsrb_datapath import tsrb_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ctrl_t         ctrl,
  output stat_t         stat,
  input  logic          func,
  input  logic          packet_usable,
  input  logic [31:0]   sequence_number,
  input  logic [15:0]   ip_total_length,
  input  logic [3:0]    ip_header_words,
  input  logic [3:0]    tcp_offset_words,
  input  logic          flag_syn,
  input  logic          flag_ack,
  input  logic          flag_fin,
  input  logic          flag_rst,
  input  logic [31:0]   data_handle,
  input  logic [31:0]   arrival_time,
  output logic          done,
  output logic [2:0]    packet_kind,
  output logic          popped,
  output logic [31:0]   popped_sequence,
  output logic [15:0]   popped_length,
  output logic [31:0]   popped_handle,
  output logic [31:0]   popped_time,
  output logic [CW-1:0] held_count
);

  entry_t        chain [DEPTH];
  logic [CW-1:0] count;
  logic [31:0]   expected;

  logic          r_push, r_usable, r_syn, r_ack, r_fin, r_rst;
  logic [31:0]   r_seq, r_handle, r_time;
  logic [15:0]   r_len;

  logic [17:0]   hdr_bytes;
  logic [17:0]   tot_ext;

  always_comb begin
    hdr_bytes = {12'd0, ip_header_words, 2'b00} + {12'd0, tcp_offset_words, 2'b00};
    tot_ext   = {2'b00, ip_total_length};
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      r_push   <= (func == FUNC_PUSH);
      r_usable <= packet_usable;
      r_seq    <= sequence_number;
      r_len    <= (tot_ext > hdr_bytes) ? 16'(tot_ext - hdr_bytes) : 16'd0;
      r_syn    <= flag_syn;
      r_ack    <= flag_ack;
      r_fin    <= flag_fin;
      r_rst    <= flag_rst;
      r_handle <= data_handle;
      r_time   <= arrival_time;
    end
  end

  kind_t cls;
  always_comb begin
    priority if (r_syn)                              cls = KIND_SYN;
    else if (r_ack && !r_fin && r_len == 16'd0)      cls = KIND_ACK;
    else if (serial_after(expected, r_seq))          cls = KIND_RETX;
    else if (r_fin)                                  cls = KIND_FIN;
    else if (r_rst)                                  cls = KIND_RST;
    else                                             cls = KIND_DATA;
  end

  logic [DEPTH-1:0] valid, after_new, seen, go_right;
  logic             tail_le, no_after, shift_mode;
  logic [DEPTH-1:0] tail_sel;
  logic [31:0]      tail_diff;

  always_comb begin
    tail_diff = 32'd0;
    for (int i = 0; i < DEPTH; i++) begin
      valid[i]     = (CW'(i) < count);
      after_new[i] = valid[i] && serial_after(chain[i].seq, r_seq);
      tail_sel[i]  = valid[i] && (CW'(i + 1) == count);
      if (tail_sel[i]) tail_diff = r_seq - chain[i].seq;
    end
    tail_le    = (count != '0) && !tail_diff[31];
    no_after   = (after_new == '0);
    shift_mode = !(tail_le || no_after);
    // Entries at or above the slot move right; the slot is the first held
    // entry after the new one, or the tail when none or when the new one is
    // not before the tail.
    for (int i = 0; i < DEPTH; i++) begin
      seen[i]     = after_new[i] || ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]);
      go_right[i] = shift_mode && valid[i] && seen[i];
    end
  end

  logic [DEPTH-1:0] first_after;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      first_after[i] = go_right[i] && ((i == 0) ? 1'b1 : !go_right[(i == 0) ? 0 : i - 1]);
    end
  end

  entry_t new_e;
  always_comb begin
    new_e.seq    = r_seq;
    new_e.len    = r_len;
    new_e.kind   = cls;
    new_e.handle = r_handle;
    new_e.tstamp = r_time;
  end

  logic full, head_ok;
  logic [31:0] end_seq;
  always_comb begin
    full    = (count == CW'(DEPTH));
    head_ok = (count != '0) && !serial_after(chain[0].seq, expected);
    end_seq = chain[0].seq + {16'd0, chain[0].len};
    stat.is_push    = r_push;
    stat.can_insert = r_usable && !full;
    stat.can_pop    = head_ok;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl.insert) begin
        if (first_after[i]) chain[i] <= new_e;
        else if (i > 0 && go_right[(i == 0) ? 0 : i - 1]) chain[i] <= chain[(i == 0) ? 0 : i - 1];
        else if (!shift_mode && !valid[i] && (i == 0 || valid[(i == 0) ? 0 : i - 1]))
          chain[i] <= new_e;
      end else if (ctrl.remove) begin
        if (i < DEPTH - 1) chain[i] <= chain[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      expected <= '0;
      done     <= 1'b0;
    end else begin
      done <= ctrl.respond;
      if (ctrl.insert) count <= count + CW'(1);
      if (ctrl.remove) count <= count - CW'(1);
      if (ctrl.respond && r_push && r_usable && r_syn) expected <= r_seq;
      if (ctrl.remove) begin
        unique case (chain[0].kind)
          KIND_SYN, KIND_FIN: expected <= expected + 32'd1;
          KIND_DATA:          expected <= end_seq;
          KIND_RETX:          if (serial_after(end_seq, expected)) expected <= end_seq;
          default:            expected <= expected;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      popped          <= ctrl.remove;
      popped_sequence <= ctrl.remove ? chain[0].seq : 32'd0;
      popped_length   <= ctrl.remove ? chain[0].len : 16'd0;
      popped_handle   <= ctrl.remove ? chain[0].handle : 32'd0;
      popped_time     <= ctrl.remove ? chain[0].tstamp : 32'd0;
      if (r_push) packet_kind <= ctrl.insert ? cls : KIND_IGNORE;
      else        packet_kind <= ctrl.remove ? chain[0].kind : KIND_IGNORE;
      held_count <= ctrl.insert ? count + CW'(1) : (ctrl.remove ? count - CW'(1) : count);
    end
  end

endmodule

FILE: hdl/tcp_sequence_reorder_buffer_unit.sv
// Top level of the TCP sequence reorder buffer.
// Depends on tsrb_pkg, tsrb_ctrl and tsrb_datapath.
`timescale 1ns / 1ps

// Each command is registered, then classified; its sequence is compared with
// every held entry in parallel and the sorted chain shifted, or a due head
// popped. The result strobe, done, rises in the cycle after that and lasts
// one cycle; the receiver cannot stall it. A new item may start as busy falls.

module tcp_sequence_reorder_buffer_unit import tsrb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic        packet_usable,
  input  logic [31:0] sequence_number,
  input  logic [15:0] ip_total_length,
  input  logic [3:0]  ip_header_words,
  input  logic [3:0]  tcp_offset_words,
  input  logic        flag_syn,
  input  logic        flag_ack,
  input  logic        flag_fin,
  input  logic        flag_rst,
  input  logic [31:0] data_handle,
  input  logic [31:0] arrival_time,
  output logic        done,
  output logic [2:0]  packet_kind,
  output logic        popped,
  output logic [31:0] popped_sequence,
  output logic [15:0] popped_length,
  output logic [31:0] popped_handle,
  output logic [31:0] popped_time,
  output logic [$clog2(DEPTH+1)-1:0] held_count
);

  ctrl_t ctrl;
  stat_t stat;

  tsrb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .busy(busy), .ctrl(ctrl)
  );

  tsrb_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .func(func), .packet_usable(packet_usable), .sequence_number(sequence_number),
    .ip_total_length(ip_total_length), .ip_header_words(ip_header_words),
    .tcp_offset_words(tcp_offset_words), .flag_syn(flag_syn), .flag_ack(flag_ack),
    .flag_fin(flag_fin), .flag_rst(flag_rst), .data_handle(data_handle),
    .arrival_time(arrival_time), .done(done), .packet_kind(packet_kind),
    .popped(popped), .popped_sequence(popped_sequence), .popped_length(popped_length),
    .popped_handle(popped_handle), .popped_time(popped_time), .held_count(held_count)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("Result strobe without a busy cycle.");

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("Controller stayed busy.");

  a_pop_kind: assert property (@(posedge clk) disable iff (rst)
    (done && !popped) |-> (popped_sequence == 32'd0 && popped_length == 16'd0))
    else $error("Empty pop carried data.");

endmodule
